[rtl/core/mpa_pkg.sv]
// shared types and constants for the max pooling block
package mpa_pkg;

  localparam int VALUE_W      = 16;
  localparam int INDEX_W      = 24;
  localparam int POOL_W       = 4;
  localparam int DIM_W        = 11;
  localparam int HEIGHT_W     = 11;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_SIZE,
    CFG_IN_HEIGHT,
    CFG_IN_WIDTH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LIM_IDLE,
    LIM_LOAD,
    LIM_DIV
  } lim_state_t;

  typedef struct packed {
    logic col_first;
    logic end_col;
    logic row_first;
    logic end_row;
  } tok_flags_t;

endpackage

[rtl/core/mpa_ram.sv]
// generic single-port-write ram with registered read
module mpa_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/mpa_fifo.sv]
// small token queue between front and back
module mpa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

[rtl/core/mpa_front.sv]
// front end: config registers, window limits, position counters, token issue
module mpa_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mpa_pkg::VALUE_W-1:0]   in_sample_value,
  input  logic                                 in_first_of_tensor,
  input  logic                                 fifo_full,
  output logic                                 tok_push,
  output mpa_pkg::tok_flags_t                  tok_flags,
  output logic signed [mpa_pkg::VALUE_W-1:0]   tok_value,
  output logic [mpa_pkg::INDEX_W-1:0]          tok_index,
  output logic [$clog2(MAX_WIDTH)-1:0]         tok_addr
);
  import mpa_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int PW   = $clog2(MAX_POOL + 1);
  localparam int PHW  = $clog2(MAX_POOL);
  localparam int DW   = (WW > HEIGHT_W) ? WW : HEIGHT_W;
  localparam int CNTW = $clog2(DW);

  logic [POOL_W-1:0] pool_size_r;
  logic [DIM_W-1:0]  in_height_r;
  logic [DIM_W-1:0]  in_width_r;

  logic [PW-1:0]       p_eff;
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  lim_state_t          state_r, state_nxt;
  logic [DW-1:0]       wsh_r, wsh_nxt, hsh_r, hsh_nxt;
  logic [PW-1:0]       wrem_r, wrem_nxt, hrem_r, hrem_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [WW-1:0]       wlim_r, wlim_nxt;
  logic [HEIGHT_W-1:0] hlim_r, hlim_nxt;
  logic [PW:0]         w_trial, h_trial;
  logic [PW-1:0]       w_rem_step, h_rem_step;

  logic [WW-1:0]       cc_r, cc_nxt, cc_eff, cc_inc;
  logic [HEIGHT_W-1:0] rc_r, rc_nxt, rc_eff, rc_inc;
  logic [PHW-1:0]      cph_r, cph_nxt, cph_eff;
  logic [PHW-1:0]      rph_r, rph_nxt, rph_eff;
  logic [CW-1:0]       wc_r, wc_nxt, wc_eff;
  logic [INDEX_W-1:0]  ei_r, ei_nxt, ei_eff;
  logic [PW-1:0]       cph_p1, rph_p1;
  logic                end_col, end_row, in_win, accept;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_W'(2);
      in_height_r <= DIM_W'(28);
      in_width_r  <= DIM_W'(28);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_POOL_SIZE: pool_size_r <= cfg_wdata[POOL_W-1:0];
        CFG_IN_HEIGHT: in_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_IN_WIDTH:  in_width_r  <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pool_size_r == '0) begin
      p_eff = PW'(1);
    end else if (32'(pool_size_r) > MAX_POOL) begin
      p_eff = PW'(MAX_POOL);
    end else begin
      p_eff = PW'(pool_size_r);
    end
    if (in_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(in_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(in_width_r);
    end
    if (in_height_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (32'(in_height_r) > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = HEIGHT_W'(in_height_r);
    end
  end

  // shift-subtract remainder, one dividend bit per cycle, width and height together
  assign w_trial    = {wrem_r, wsh_r[DW-1]};
  assign h_trial    = {hrem_r, hsh_r[DW-1]};
  assign w_rem_step = (w_trial >= {1'b0, p_eff}) ? PW'(w_trial - {1'b0, p_eff}) : PW'(w_trial);
  assign h_rem_step = (h_trial >= {1'b0, p_eff}) ? PW'(h_trial - {1'b0, p_eff}) : PW'(h_trial);

  always_comb begin
    state_nxt = state_r;
    wsh_nxt   = wsh_r;
    hsh_nxt   = hsh_r;
    wrem_nxt  = wrem_r;
    hrem_nxt  = hrem_r;
    cnt_nxt   = cnt_r;
    wlim_nxt  = wlim_r;
    hlim_nxt  = hlim_r;
    case (state_r)
      LIM_LOAD: begin
        wsh_nxt   = DW'(w_eff);
        hsh_nxt   = DW'(h_eff);
        wrem_nxt  = '0;
        hrem_nxt  = '0;
        cnt_nxt   = CNTW'(DW - 1);
        state_nxt = LIM_DIV;
      end
      LIM_DIV: begin
        wsh_nxt  = wsh_r << 1;
        hsh_nxt  = hsh_r << 1;
        wrem_nxt = w_rem_step;
        hrem_nxt = h_rem_step;
        cnt_nxt  = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          wlim_nxt  = w_eff - WW'(w_rem_step);
          hlim_nxt  = h_eff - HEIGHT_W'(h_rem_step);
          state_nxt = LIM_IDLE;
        end
      end
      LIM_IDLE: ;
      default: state_nxt = LIM_LOAD;
    endcase
    if (cfg_we) begin
      state_nxt = LIM_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LIM_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wsh_r  <= wsh_nxt;
    hsh_r  <= hsh_nxt;
    wrem_r <= wrem_nxt;
    hrem_r <= hrem_nxt;
    cnt_r  <= cnt_nxt;
    wlim_r <= wlim_nxt;
    hlim_r <= hlim_nxt;
  end

  // position counters
  assign in_stall = (state_r != LIM_IDLE) || fifo_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cc_eff  = in_first_of_tensor ? '0 : cc_r;
    rc_eff  = in_first_of_tensor ? '0 : rc_r;
    cph_eff = in_first_of_tensor ? '0 : cph_r;
    rph_eff = in_first_of_tensor ? '0 : rph_r;
    wc_eff  = in_first_of_tensor ? '0 : wc_r;
    ei_eff  = in_first_of_tensor ? '0 : ei_r;

    cph_p1  = PW'(cph_eff) + PW'(1);
    rph_p1  = PW'(rph_eff) + PW'(1);
    end_col = (cph_p1 >= p_eff);
    end_row = (rph_p1 >= p_eff);
    in_win  = (cc_eff < wlim_r) && (rc_eff < hlim_r);
    cc_inc  = cc_eff + WW'(1);
    rc_inc  = rc_eff + HEIGHT_W'(1);

    ei_nxt  = ei_eff + INDEX_W'(1);
    cc_nxt  = cc_inc;
    rc_nxt  = rc_eff;
    rph_nxt = rph_eff;
    if (end_col) begin
      cph_nxt = '0;
      wc_nxt  = wc_eff + CW'(1);
    end else begin
      cph_nxt = PHW'(cph_p1);
      wc_nxt  = wc_eff;
    end
    if (cc_inc >= w_eff) begin
      cc_nxt  = '0;
      cph_nxt = '0;
      wc_nxt  = '0;
      rc_nxt  = rc_inc;
      rph_nxt = end_row ? '0 : PHW'(rph_p1);
      if (rc_inc >= h_eff) begin
        rc_nxt  = '0;
        rph_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= '0;
      rc_r  <= '0;
      cph_r <= '0;
      rph_r <= '0;
      wc_r  <= '0;
      ei_r  <= '0;
    end else if (accept) begin
      cc_r  <= cc_nxt;
      rc_r  <= rc_nxt;
      cph_r <= cph_nxt;
      rph_r <= rph_nxt;
      wc_r  <= wc_nxt;
      ei_r  <= ei_nxt;
    end
  end

  assign tok_push            = accept && in_win;
  assign tok_flags.col_first = (cph_eff == '0);
  assign tok_flags.end_col   = end_col;
  assign tok_flags.row_first = (rph_eff == '0);
  assign tok_flags.end_row   = end_row;
  assign tok_value           = in_sample_value;
  assign tok_index           = ei_eff;
  assign tok_addr            = wc_eff;

  a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n) cfg_we |=> in_stall)
    else $error("input taken while limits are recomputed");

endmodule

[rtl/core/mpa_back.sv]
// back end: running row max, band store merge, result register
module mpa_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fifo_empty,
  output logic                               fifo_pop,
  input  mpa_pkg::tok_flags_t                tok_flags,
  input  logic signed [mpa_pkg::VALUE_W-1:0] tok_value,
  input  logic [mpa_pkg::INDEX_W-1:0]        tok_index,
  input  logic [$clog2(MAX_WIDTH)-1:0]       tok_addr,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mpa_pkg::VALUE_W-1:0] out_max_value,
  output logic [mpa_pkg::INDEX_W-1:0]        out_max_index
);
  import mpa_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = VALUE_W + INDEX_W;

  logic signed [VALUE_W-1:0] run_val_r, run_val_nxt;
  logic [INDEX_W-1:0]        run_idx_r, run_idx_nxt;
  logic                      take, load_b, b_free, b_go, out_free, emit;

  logic                      b_vld_r;
  logic signed [VALUE_W-1:0] b_val_r;
  logic [INDEX_W-1:0]        b_idx_r;
  logic                      b_row_first_r, b_end_row_r;
  logic [CW-1:0]             b_addr_r;

  logic                      ram_we, ram_re;
  logic [RW-1:0]             ram_wdata, ram_rdata;
  logic signed [VALUE_W-1:0] ram_val;
  logic [INDEX_W-1:0]        ram_idx;
  logic signed [VALUE_W-1:0] best_val;
  logic [INDEX_W-1:0]        best_idx;
  logic                      keep_b;

  logic                      out_vld_r;

  assign out_free = !out_vld_r || !out_stall;
  assign b_go     = b_vld_r && (!b_end_row_r || out_free);
  assign b_free   = !b_vld_r || b_go;
  assign fifo_pop = !fifo_empty && b_free;
  assign load_b   = fifo_pop && tok_flags.end_col;

  assign take        = tok_flags.col_first || (tok_value > run_val_r);
  assign run_val_nxt = take ? tok_value : run_val_r;
  assign run_idx_nxt = take ? tok_index : run_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_val_r <= '0;
      run_idx_r <= '0;
    end else if (fifo_pop) begin
      run_val_r <= run_val_nxt;
      run_idx_r <= run_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_free) begin
      b_vld_r <= load_b;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_val_r       <= run_val_nxt;
      b_idx_r       <= run_idx_nxt;
      b_row_first_r <= tok_flags.row_first;
      b_end_row_r   <= tok_flags.end_row;
      b_addr_r      <= tok_addr;
    end
  end

  // band store, one entry per window column
  assign ram_re    = load_b && !tok_flags.row_first;
  assign ram_val   = ram_rdata[RW-1 -: VALUE_W];
  assign ram_idx   = ram_rdata[INDEX_W-1:0];
  assign keep_b    = b_row_first_r || (b_val_r > ram_val);
  assign best_val  = keep_b ? b_val_r : ram_val;
  assign best_idx  = keep_b ? b_idx_r : ram_idx;
  assign ram_we    = b_go && !b_end_row_r;
  assign ram_wdata = {best_val, best_idx};
  assign emit      = b_go && b_end_row_r;

  mpa_ram #(
    .W     (RW),
    .DEPTH (MAX_WIDTH)
  ) u_band_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tok_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_max_value <= best_val;
      out_max_index <= best_idx;
    end
  end

  assign out_valid = out_vld_r;

  a_merge_holds: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && !b_go |=> b_vld_r && $stable(b_addr_r) && $stable(b_end_row_r))
    else $error("merge stage lost its transaction while blocked");
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(b_vld_r && b_end_row_r))
    else $error("result without a finished window");

endmodule

[rtl/core/max_pool_2d_argmax.sv]
// top level of the streaming 2-d max pooling block with argmax
//
// channel  dir  handshake               payload
// in_      in   in_valid / in_stall     in_sample_value, in_first_of_tensor
// out_     out  out_valid / out_stall   out_max_value, out_max_index
// cfg_     in   cfg_we                  cfg_index, cfg_wdata
//
// one sample per cycle while in_stall is low, with a single pass through the band store
// a result passes the queue, the merge register and the output register after the sample that closes its window
// after reset and after every cfg write in_stall stays high while a shift-subtract unit
// recomputes the whole-window limits
// rst_n is synchronous, active low; a stalled output backs up through a 4-entry queue
module max_pool_2d_argmax #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mpa_pkg::VALUE_W-1:0] in_sample_value,
  input  logic                               in_first_of_tensor,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mpa_pkg::VALUE_W-1:0] out_max_value,
  output logic [mpa_pkg::INDEX_W-1:0]        out_max_index
);
  import mpa_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int FLW   = $bits(tok_flags_t);
  localparam int TOKW  = FLW + VALUE_W + INDEX_W + CW;
  localparam int QUEUE_DEPTH = 4;

  logic                      f_push, f_full, f_pop, f_empty;
  logic [TOKW-1:0]           f_din, f_dout;
  tok_flags_t                fr_flags, bk_flags;
  logic signed [VALUE_W-1:0] fr_value, bk_value;
  logic [INDEX_W-1:0]        fr_index, bk_index;
  logic [CW-1:0]             fr_addr, bk_addr;

  mpa_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_POOL  (MAX_POOL)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_value    (in_sample_value),
    .in_first_of_tensor (in_first_of_tensor),
    .fifo_full          (f_full),
    .tok_push           (f_push),
    .tok_flags          (fr_flags),
    .tok_value          (fr_value),
    .tok_index          (fr_index),
    .tok_addr           (fr_addr)
  );

  assign f_din = {fr_flags, fr_value, fr_index, fr_addr};

  mpa_fifo #(
    .W     (TOKW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_din),
    .full  (f_full),
    .pop   (f_pop),
    .dout  (f_dout),
    .empty (f_empty)
  );

  assign bk_flags = tok_flags_t'(f_dout[TOKW-1 -: FLW]);
  assign bk_value = f_dout[TOKW-FLW-1 -: VALUE_W];
  assign bk_index = f_dout[CW+INDEX_W-1 -: INDEX_W];
  assign bk_addr  = f_dout[CW-1:0];

  mpa_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_empty    (f_empty),
    .fifo_pop      (f_pop),
    .tok_flags     (bk_flags),
    .tok_value     (bk_value),
    .tok_index     (bk_index),
    .tok_addr      (bk_addr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_max_value (out_max_value),
    .out_max_index (out_max_index)
  );

endmodule

[tb/sv/tb_max_pool_2d_argmax.sv]
// testbench for max_pool_2d_argmax: random and directed samples checked against a pooling predictor
`timescale 1ns / 100ps

module tb_max_pool_2d_argmax;
  import mpa_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_POOL  = 8;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      first;
  } sample_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } window_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [VALUE_W-1:0]   in_sample_value = '0;
  logic                        in_first_of_tensor = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [VALUE_W-1:0]   out_max_value;
  logic [INDEX_W-1:0]          out_max_index;

  sample_t sample_fifo[$];
  window_t expected_windows[$];
  int      errors = 0;
  int      send_idle_pct = 17;
  int      recv_idle_pct = 65;

  // predictor state
  logic [POOL_W-1:0]         pool_cfg = 4'd2;
  logic [DIM_W-1:0]          height_cfg = 11'd28;
  logic [DIM_W-1:0]          width_cfg = 11'd28;
  int                        col_cnt = 0;
  int                        row_cnt = 0;
  int                        col_ph = 0;
  int                        row_ph = 0;
  int                        win_col = 0;
  logic [INDEX_W-1:0]        elem_idx = '0;
  logic signed [VALUE_W-1:0] run_max = '0;
  logic [INDEX_W-1:0]        run_idx = '0;
  logic signed [VALUE_W-1:0] band_max [MAX_WIDTH];
  logic [INDEX_W-1:0]        band_idx [MAX_WIDTH];

  max_pool_2d_argmax #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_POOL (MAX_POOL)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .in_first_of_tensor(in_first_of_tensor),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_max_value     (out_max_value),
    .out_max_index     (out_max_index)
  );

  always #10 clk = ~clk;

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // predicts the window result of one sample and queues the sample for the driver
  task automatic send_sample(input logic signed [VALUE_W-1:0] s, input logic first);
    int p, h, w;
    logic signed [VALUE_W-1:0] best, sm;
    logic [INDEX_W-1:0] best_idx, si;
    bit slot;
    sample_t item;
    p = clamp_dim(pool_cfg, MAX_POOL);
    h = clamp_dim(height_cfg, HEIGHT_LIMIT);
    w = clamp_dim(width_cfg, MAX_WIDTH);
    item.value = s;
    item.first = first;
    sample_fifo.push_back(item);
    if (first) begin
      col_cnt = 0;
      row_cnt = 0;
      col_ph = 0;
      row_ph = 0;
      win_col = 0;
      elem_idx = '0;
    end
    if (col_cnt < (w / p) * p && row_cnt < (h / p) * p) begin
      if (col_ph == 0 || s > run_max) begin
        run_max = s;
        run_idx = elem_idx;
      end
      if (col_ph + 1 >= p) begin
        best = run_max;
        best_idx = run_idx;
        slot = win_col < MAX_WIDTH;
        if (row_ph != 0) begin
          sm = slot ? band_max[win_col] : '0;
          si = slot ? band_idx[win_col] : '0;
          if (!(best > sm)) begin
            best = sm;
            best_idx = si;
          end
        end
        if (row_ph + 1 >= p) begin
          expected_windows.push_back('{best, best_idx});
        end else if (slot) begin
          band_max[win_col] = best;
          band_idx[win_col] = best_idx;
        end
      end
    end
    elem_idx = elem_idx + 1'b1;
    col_cnt++;
    if (col_ph + 1 >= p) begin
      col_ph = 0;
      win_col++;
    end else begin
      col_ph++;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      col_ph = 0;
      win_col = 0;
      row_cnt++;
      if (row_ph + 1 >= p) row_ph = 0;
      else row_ph++;
      if (row_cnt >= h) begin
        row_cnt = 0;
        row_ph = 0;
      end
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return VALUE_W'($signed($urandom_range(0, 3)) - 2);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic settle();
    do @(negedge clk); while (sample_fifo.size() != 0 || in_valid);
    while (expected_windows.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d[CFG_DATA_W-1:0];
    case (r)
      CFG_POOL_SIZE: pool_cfg = d[POOL_W-1:0];
      CFG_IN_HEIGHT: height_cfg = d[DIM_W-1:0];
      CFG_IN_WIDTH:  width_cfg = d[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int pool, input int rows, input int cols);
    settle();
    write_reg(CFG_POOL_SIZE, pool);
    write_reg(CFG_IN_HEIGHT, rows);
    write_reg(CFG_IN_WIDTH, cols);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // random samples; a restart flag at each tensor start (the first only if fresh) and at random
  task automatic random_phase(input int pool, input int rows, input int cols, input int n,
                              input bit fresh);
    int span;
    bit f;
    configure(pool, rows, cols);
    span = clamp_dim(rows, HEIGHT_LIMIT) * clamp_dim(cols, MAX_WIDTH);
    for (int k = 0; k < n; k++) begin
      f = ((k % span == 0) && (fresh || k != 0)) || ($urandom_range(0, 249) == 0);
      send_sample(rand_sample(), f);
    end
  endtask

  always @(posedge clk) begin : drive
    sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (sample_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = sample_fifo.pop_front();
        in_valid <= 1'b1;
        in_sample_value <= nxt.value;
        in_first_of_tensor <= nxt.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    window_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction value %0d index %0d",
                                    out_max_value, out_max_index));
        end else begin
          want = expected_windows.pop_front();
          if (out_max_value !== want.value)
            report_mismatch($sformatf("max_value %0d, expected %0d", out_max_value,
                                      want.value));
          if (out_max_index !== want.index)
            report_mismatch($sformatf("max_index %0d, expected %0d", out_max_index,
                                      want.index));
        end
      end
    end
  end

  initial begin
    int grid [20];
    grid = '{32767, 32767, -32768, -32768, 5,
             100, 32767, -32768, -32768, 7,
             -1, -1, 0, -2, 3,
             0, -1, 0, 1, 9};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ties, extremes and a leftover column
    configure(2, 4, 5);
    for (int k = 0; k < 20; k++) send_sample(VALUE_W'(grid[k]), k == 0);
    // zero sizes and a restart in the middle of a stream
    configure(0, 0, 0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);

    random_phase(1, 3, 4, 24, 1'b1);
    random_phase(2, 6, 7, 84, 1'b1);
    random_phase(3, 9, 10, 100, 1'b1);

    settle();
    send_idle_pct = 65;
    recv_idle_pct = 17;
    random_phase(15, 17, 16, 136, 1'b1);
    random_phase(1, 2047, 5, 60, 1'b1);
    random_phase(8, 8, 8, 66, 1'b1);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(1, 1, 2047, 1030, 1'b1);
    // height lowered below the current row inside a tensor
    random_phase(2, 6, 6, 24, 1'b1);
    random_phase(2, 3, 6, 40, 1'b0);
    random_phase(5, 11, 12, 120, 1'b1);

    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
